[hdl/mandelbrot_escape_count_defines.svh]
// Assertion macros for the escape-time counter.
// Used by files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef MANDELBROT_ESCAPE_COUNT_DEFINES_SVH
`define MANDELBROT_ESCAPE_COUNT_DEFINES_SVH

// condition holds at every edge out of reset
`define MEC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MEC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define MEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mec_pkg.sv]
// Shared types and constants for the escape-time counter.
// No dependencies; imported by mec_mul, mec_ctrl and the top level.
package mec_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned OUT_W  = 16;

  localparam logic [CFG_W-1:0] MAX_COUNT_RST = 16'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RR,
    ST_MUL_II,
    ST_CHECK,
    ST_MUL_RI,
    ST_UPDATE
  } state_e;

  typedef enum logic [1:0] {
    MUL_RR,
    MUL_II,
    MUL_RI
  } mul_sel_e;

  typedef struct packed {
    logic     in_ready;
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     save_rr;
    logic     step;
    logic     update;
    logic     finish;
  } ctrl_t;

  typedef struct packed {
    logic escape;
    logic more;
    logic slot_free;
  } stat_t;

endpackage

[hdl/mec_mul.sv]
// Shared signed 32x32 multiplier with registered 64-bit product.
// Operand pair chosen per cycle from z; depends on mec_pkg.
module mec_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  mec_pkg::mul_sel_e                    sel_i,
  input  logic signed [mec_pkg::DATA_W-1:0]    re_i,
  input  logic signed [mec_pkg::DATA_W-1:0]    im_i,
  output logic signed [mec_pkg::PROD_W-1:0]    prod_o
);
  import mec_pkg::*;

  logic signed [DATA_W-1:0] a, b;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  always_comb begin
    case (sel_i)
      MUL_RR: begin
        a = re_i;
        b = re_i;
      end
      MUL_II: begin
        a = im_i;
        b = im_i;
      end
      MUL_RI: begin
        a = re_i;
        b = im_i;
      end
      default: begin
        a = re_i;
        b = im_i;
      end
    endcase
    prod_d = PROD_W'(a) * PROD_W'(b);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

[hdl/mec_ctrl.sv]
// Sequencer for the escape-time counter: orders the multiplier passes,
// the escape check and the z update. Depends on mec_pkg.
module mec_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  mec_pkg::stat_t  stat_i,
  output mec_pkg::ctrl_t  ctrl_o
);
  import mec_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL_RR;
      end
      ST_MUL_RR: state_d = ST_MUL_II;
      ST_MUL_II: state_d = ST_CHECK;
      ST_CHECK: begin
        if (!stat_i.escape && stat_i.more) begin
          state_d = ST_MUL_RI;
        end else if (stat_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL_RI: state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_MUL_RR;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.in_ready = (state_q == ST_IDLE);
    ctrl_o.load     = (state_q == ST_IDLE) && in_valid_i;
    ctrl_o.mul_en   = state_q inside {ST_MUL_RR, ST_MUL_II, ST_MUL_RI};
    case (state_q)
      ST_MUL_II: ctrl_o.mul_sel = MUL_II;
      ST_MUL_RI: ctrl_o.mul_sel = MUL_RI;
      default:   ctrl_o.mul_sel = MUL_RR;
    endcase
    ctrl_o.save_rr = (state_q == ST_MUL_II);
    ctrl_o.step    = (state_q == ST_CHECK) && !stat_i.escape && stat_i.more;
    ctrl_o.finish  = (state_q == ST_CHECK) && (stat_i.escape || !stat_i.more)
                     && stat_i.slot_free;
    ctrl_o.update  = (state_q == ST_UPDATE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/mandelbrot_escape_count.sv]
// Escape-time counter: one shared 32x32 multiplier, three passes per iteration.
// The five-state loop round the multiplier squares z_re, squares z_im, checks escape and
// the limit, forms the cross product and updates z. One point at a time; the next is
// accepted the cycle after the result is loaded, and a result held by the sink stalls the
// loop in its check state.
// Reset (asynchronous, active low) idles the block, empties the output, max_count 255.
module mandelbrot_escape_count #(
  parameter int unsigned FRAC_BITS  = 28,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              max_count_we_i,
  input  logic [mec_pkg::CFG_W-1:0]         max_count_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [mec_pkg::DATA_W-1:0] c_re_i,
  input  logic signed [mec_pkg::DATA_W-1:0] c_im_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mec_pkg::OUT_W-1:0]         escape_count_o
);
  import mec_pkg::*;
  `include "mandelbrot_escape_count_defines.svh"

  localparam int unsigned THR_SHIFT = 2 * FRAC_BITS + 2;
  localparam bit          ESC_EN    = (THR_SHIFT < PROD_W);
  localparam logic [PROD_W-1:0] THR = ESC_EN ? (PROD_W'(1) << (THR_SHIFT % PROD_W))
                                             : '0;
  localparam logic [32:0] CNT_MAX   = (33'd1 << COUNT_BITS) - 33'd1;
  localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
  localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

  ctrl_t ctrl;
  stat_t stat;

  logic [CFG_W-1:0]         max_count_q;
  logic signed [DATA_W-1:0] z_re_q, z_im_q, c_re_q, c_im_q;
  logic signed [PROD_W-1:0] prod, rr_q, diff_q;
  logic [COUNT_BITS-1:0]    count_q;
  logic                     first_q;
  logic                     out_valid_q;
  logic [OUT_W-1:0]         out_q, out_d;

  logic [PROD_W-1:0]        mag;
  logic [32:0]              limit, count_w, count_nxt;
  logic signed [64:0]       re_sum, im_sum;
  logic signed [DATA_W-1:0] re_new, im_new;

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [64:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI)      r = SAT_HI[DATA_W-1:0];
    else if (v < SAT_LO) r = SAT_LO[DATA_W-1:0];
    else                 r = v[DATA_W-1:0];
    return r;
  endfunction

  mec_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .sel_i  (ctrl.mul_sel),
    .re_i   (z_re_q),
    .im_i   (z_im_q),
    .prod_o (prod)
  );

  mec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  always_comb begin
    mag       = PROD_W'($unsigned(rr_q)) + PROD_W'($unsigned(prod));
    limit     = (33'(max_count_q) > CNT_MAX) ? CNT_MAX : 33'(max_count_q);
    count_w   = 33'(count_q);
    count_nxt = first_q ? count_w : count_w + 33'd1;

    stat.escape    = ESC_EN && (mag > THR);
    stat.more      = count_nxt < limit;
    stat.slot_free = !out_valid_q || out_ready_i;

    if (stat.escape) begin
      out_d = first_q ? '0 : count_w[OUT_W-1:0];
    end else begin
      out_d = count_nxt[OUT_W-1:0];
    end

    re_sum = 65'(diff_q >>> FRAC_BITS) + 65'(c_re_q);
    im_sum = 65'(prod >>> (FRAC_BITS - 1)) + 65'(c_im_q);
    re_new = sat(re_sum);
    im_new = sat(im_sum);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      c_re_q <= c_re_i;
      c_im_q <= c_im_i;
      z_re_q <= c_re_i;
      z_im_q <= c_im_i;
    end else if (ctrl.update) begin
      z_re_q <= re_new;
      z_im_q <= im_new;
    end
    if (ctrl.save_rr) begin
      rr_q <= prod;
    end
    if (ctrl.step) begin
      diff_q <= rr_q - prod;
    end
    if (ctrl.finish) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q <= MAX_COUNT_RST;
      count_q     <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (max_count_we_i) begin
        max_count_q <= max_count_i;
      end
      if (ctrl.load) begin
        count_q <= COUNT_BITS'(1);
        first_q <= 1'b1;
      end else if (ctrl.step) begin
        count_q <= count_nxt[COUNT_BITS-1:0];
        first_q <= 1'b0;
      end
      if (ctrl.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o     = ctrl.in_ready;
  assign out_valid_o    = out_valid_q;
  assign escape_count_o = out_q;

  `MEC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `MEC_ASSERT_IMPL(a_count_live, !in_ready_o, count_q != '0, "count zero while busy")
  `MEC_ASSERT_IMPL(a_no_overwrite, ctrl.finish, !out_valid_q || out_ready_i, "result overwritten")
  `MEC_ASSERT_NEXT(a_result_in_limit, ctrl.finish && !stat.escape,
                   33'(out_q) <= CNT_MAX, "result above counter range")

endmodule
